>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed chunk store.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KCSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KCSA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define KCSA_ASSERT(lbl, prop, msg)
`define KCSA_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/core/kcsa_pkg.sv
// ----------------------------------------------------------------------------
// kcsa_pkg
// Shared constants, codes and types of the keyed chunk store allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package kcsa_pkg;
	localparam int MEM_BYTES = 1024;
	localparam int KEY_MAX = 32;
	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int KC_W = $clog2(KEY_MAX + 1);
	localparam int KI_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int LEN_W = 10;
	localparam int PLEN_W = 16;
	localparam int CUR_W = ((ADDR_W > PLEN_W) ? ADDR_W : PLEN_W) + 2;
	localparam int HC_W = $clog2(KEY_MAX + 4);
	localparam int HDR_BYTES = 3;
	localparam int IN_DATA_W = 24;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 16;

	localparam logic [7:0] MARK_MAGIC = 8'(8'h1a << 1);
	localparam logic [7:0] MARK_MASK = 8'hfe;
	localparam logic [7:0] ERASED = 8'hff;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_FREE = 2'd2;
	localparam logic [1:0] REQ_BAD = 2'd3;

	localparam logic [2:0] STAT_ACCEPTED = 3'd0;
	localparam logic [2:0] STAT_SUCCESS = 3'd1;
	localparam logic [2:0] STAT_KEY_USED = 3'd2;
	localparam logic [2:0] STAT_NO_SPACE = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [2:0] STAT_KEY_LONG = 3'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic item_kind;
		logic [7:0] byte_value;
		logic is_last;
		logic [LEN_W-1:0] data_length;
	} item_t;
endpackage
`default_nettype wire

>>> rtl/core/keyed_chunk_store_allocator_top.sv
// ----------------------------------------------------------------------------
// keyed_chunk_store_allocator_top
// Keyed chunk allocator over a 1024-byte store with a stream interface.
// ----------------------------------------------------------------------------
// After reset the store is erased to 0xFF, during which s_tready stays
// low. Each input word gives exactly one result word. A read data item
// passes through a wait state because of the registered store read, and
// the last key byte, unless the key is too long or the request type is
// bad, starts a walk of the chunk chain through the single store port,
// with a second walk when a write has to find room, and a header write
// when a new chunk is placed. A two-word input queue lets words arrive
// during a walk.
`default_nettype none
module keyed_chunk_store_allocator_top import kcsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [IN_DATA_W-1:0] s_tdata, // byte_value, data_length, zero fill
	input wire logic [IN_USER_W-1:0] s_tuser, // req_type, item_kind
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata, // status, read_byte, zero fill
	output logic m_tlast
);
	logic en;
	logic q_valid;
	logic q_pop;
	item_t q_item;

	kcsa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.en(en),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	kcsa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

>>> rtl/core/kcsa_front.sv
// ----------------------------------------------------------------------------
// kcsa_front
// Input side: takes request words, splits them into fields and holds them
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module kcsa_front import kcsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [IN_DATA_W-1:0] s_tdata, // byte_value, data_length, zero fill
	input wire logic [IN_USER_W-1:0] s_tuser, // req_type, item_kind
	input wire logic s_tlast,
	input wire logic en,
	output logic q_valid,
	output item_t q_item,
	input wire logic q_pop
);
	item_t buf_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic push;
	item_t in_item;

	always_comb begin
		in_item.req_type = s_tuser[1:0];
		in_item.item_kind = s_tuser[2];
		in_item.byte_value = s_tdata[7:0];
		in_item.is_last = s_tlast;
		in_item.data_length = s_tdata[8 +: LEN_W];
	end

	assign s_tready = en && (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/kcsa_back.sv
// ----------------------------------------------------------------------------
// kcsa_back
// Sequencer: owns the byte store and key buffer, walks the chunk chain,
// writes headers and data, marks freed chunks, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module kcsa_back import kcsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	output logic en,
	input wire logic q_valid,
	input wire item_t q_item,
	output logic q_pop,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata, // status, read_byte, zero fill
	output logic m_tlast
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD_WAIT, S_W_MARK, S_W_MCHK, S_W_LLO, S_W_LHI, S_W_KEY,
		S_W_DEC, S_LIVE_HIT, S_LIVE_MISS, S_PLACE_HIT, S_H_WR, S_F_WR, S_EMIT
	} state_t;
	typedef enum logic [1:0] {PH_KEY, PH_WRITE, PH_READ} phase_t;

	localparam logic [CUR_W-1:0] MEM_END = CUR_W'(MEM_BYTES);
	localparam logic [CUR_W-1:0] HDR_C = CUR_W'(HDR_BYTES);
	localparam logic [CUR_W-1:0] ONE_C = CUR_W'(1);

	logic [7:0] mem_q [MEM_BYTES];
	logic [7:0] rdata_q;
	logic roob_q;
	logic [7:0] kb_q [KEY_MAX];

	state_t state_q;
	phase_t phase_q;
	logic [KC_W-1:0] kc_q;
	logic closed_q;
	logic over_q;
	logic [CUR_W-1:0] ptr_q;
	logic [LEN_W-1:0] left_q;
	logic [1:0] req_q;
	logic [LEN_W-1:0] len_q;
	logic place_q;
	logic [CUR_W-1:0] a_q;
	logic [7:0] mark_q;
	logic [PLEN_W-1:0] plen_q;
	logic [CUR_W-1:0] i_q;
	logic [CUR_W-1:0] sp_q;
	logic mism_q;
	logic [2:0] st_q;
	logic done_q;
	logic [ADDR_W-1:0] clr_q;
	logic [HC_W-1:0] hcnt_q;
	logic rdlast_q;
	logic [2:0] ost_q;
	logic [7:0] orb_q;

	logic [CUR_W-1:0] mem_addr;
	logic mem_we;
	logic [7:0] mem_wd;
	logic mem_oob;
	logic [7:0] rd_byte;
	logic out_free;
	logic key_take;
	logic kb_we;
	logic over_now;
	logic [CUR_W-1:0] kc_c;
	logic [CUR_W-1:0] len_c;
	logic [CUR_W-1:0] plen_c;
	logic [CUR_W-1:0] data_start;
	logic [CUR_W-1:0] anext;
	logic [CUR_W-1:0] hc_c;
	logic data_end;
	logic [7:0] hdr_byte;

	assign en = (state_q != S_CLEAR);
	assign out_free = !m_tvalid || m_tready;
	assign q_pop = (state_q == S_IDLE) && q_valid && out_free;
	assign rd_byte = roob_q ? ERASED : rdata_q;
	assign kc_c = CUR_W'(kc_q);
	assign len_c = CUR_W'(len_q);
	assign plen_c = CUR_W'(plen_q);
	assign hc_c = CUR_W'(hcnt_q);
	assign data_start = a_q + HDR_C + kc_c + ONE_C;
	assign anext = a_q + HDR_C + i_q + ONE_C + plen_c;
	assign data_end = (left_q <= LEN_W'(1));
	assign key_take = q_pop && (phase_q == PH_KEY) && !q_item.item_kind && !closed_q
		&& !over_q;
	assign kb_we = key_take && (q_item.byte_value != 8'd0) && (kc_q < KC_W'(KEY_MAX));
	assign over_now = over_q || (key_take && (q_item.byte_value != 8'd0)
		&& (kc_q >= KC_W'(KEY_MAX)));
	assign m_tdata = {5'd0, orb_q, ost_q};

	always_comb begin
		if (hcnt_q == HC_W'(0)) begin
			hdr_byte = MARK_MAGIC;
		end else if (hcnt_q == HC_W'(1)) begin
			hdr_byte = len_q[7:0];
		end else if (hcnt_q == HC_W'(2)) begin
			hdr_byte = 8'(len_q >> 8);
		end else if (hc_c < HDR_C + kc_c) begin
			hdr_byte = kb_q[KI_W'(hc_c - HDR_C)];
		end else begin
			hdr_byte = 8'd0;
		end
	end

	always_comb begin
		mem_addr = ptr_q;
		mem_we = 1'b0;
		mem_wd = q_item.byte_value;
		case (state_q)
			S_CLEAR: begin
				mem_addr = CUR_W'(clr_q);
				mem_we = 1'b1;
				mem_wd = ERASED;
			end
			S_IDLE: begin
				mem_we = q_pop && (phase_q == PH_WRITE);
			end
			S_W_MARK: mem_addr = a_q;
			S_W_MCHK: mem_addr = a_q + ONE_C;
			S_W_LLO: mem_addr = a_q + CUR_W'(2);
			S_W_LHI: mem_addr = a_q + HDR_C;
			S_W_KEY: mem_addr = sp_q + ONE_C;
			S_H_WR: begin
				mem_addr = a_q + hc_c;
				mem_we = 1'b1;
				mem_wd = hdr_byte;
			end
			S_F_WR: begin
				mem_addr = a_q;
				mem_we = 1'b1;
				mem_wd = mark_q | 8'd1;
			end
			default: mem_addr = ptr_q;
		endcase
	end

	assign mem_oob = (mem_addr >= MEM_END);

	always_ff @(posedge clk) begin
		if (mem_we && !mem_oob) begin
			mem_q[mem_addr[ADDR_W-1:0]] <= mem_wd;
		end
		rdata_q <= mem_q[mem_addr[ADDR_W-1:0]];
		roob_q <= mem_oob;
		if (kb_we) begin
			kb_q[kc_q[KI_W-1:0]] <= q_item.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= PH_KEY;
			kc_q <= '0;
			closed_q <= 1'b0;
			over_q <= 1'b0;
			ptr_q <= '0;
			left_q <= '0;
			req_q <= REQ_WRITE;
			len_q <= '0;
			place_q <= 1'b0;
			a_q <= '0;
			mark_q <= '0;
			plen_q <= '0;
			i_q <= '0;
			sp_q <= '0;
			mism_q <= 1'b0;
			st_q <= STAT_ACCEPTED;
			done_q <= 1'b0;
			clr_q <= '0;
			hcnt_q <= '0;
			rdlast_q <= 1'b0;
			m_tvalid <= 1'b0;
			ost_q <= STAT_ACCEPTED;
			orb_q <= '0;
			m_tlast <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MEM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						case (phase_q)
							PH_WRITE: begin
								ptr_q <= ptr_q + ONE_C;
								left_q <= left_q - LEN_W'(1);
								m_tvalid <= 1'b1;
								orb_q <= 8'd0;
								if (data_end || q_item.is_last) begin
									phase_q <= PH_KEY;
									left_q <= '0;
									ost_q <= STAT_SUCCESS;
									m_tlast <= 1'b1;
								end else begin
									ost_q <= STAT_ACCEPTED;
									m_tlast <= 1'b0;
								end
							end
							PH_READ: begin
								rdlast_q <= q_item.is_last;
								state_q <= S_RD_WAIT;
							end
							default: begin
								m_tvalid <= 1'b1;
								orb_q <= 8'd0;
								ost_q <= STAT_ACCEPTED;
								m_tlast <= 1'b0;
								if (key_take) begin
									if (q_item.byte_value == 8'd0) begin
										closed_q <= 1'b1;
									end else if (kb_we) begin
										kc_q <= kc_q + KC_W'(1);
									end else begin
										over_q <= 1'b1;
									end
								end
								if (!q_item.item_kind && q_item.is_last) begin
									if (over_now || q_item.req_type == REQ_BAD) begin
										ost_q <= over_now ? STAT_KEY_LONG : STAT_NOT_FOUND;
										m_tlast <= 1'b1;
										kc_q <= '0;
										closed_q <= 1'b0;
										over_q <= 1'b0;
									end else begin
										m_tvalid <= 1'b0;
										req_q <= q_item.req_type;
										len_q <= q_item.data_length;
										a_q <= '0;
										place_q <= 1'b0;
										state_q <= S_W_MARK;
									end
								end
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					ptr_q <= ptr_q + ONE_C;
					left_q <= left_q - LEN_W'(1);
					m_tvalid <= 1'b1;
					orb_q <= rd_byte;
					state_q <= S_IDLE;
					if (data_end || rdlast_q) begin
						phase_q <= PH_KEY;
						left_q <= '0;
						ost_q <= STAT_SUCCESS;
						m_tlast <= 1'b1;
					end else begin
						ost_q <= STAT_ACCEPTED;
						m_tlast <= 1'b0;
					end
				end
				S_W_MARK: state_q <= S_W_MCHK;
				S_W_MCHK: begin
					if ((rd_byte & MARK_MASK) != MARK_MAGIC) begin
						if (!place_q) begin
							state_q <= S_LIVE_MISS;
						end else if (data_start + len_c < MEM_END) begin
							state_q <= S_PLACE_HIT;
						end else begin
							st_q <= STAT_NO_SPACE;
							done_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end else begin
						mark_q <= rd_byte;
						state_q <= S_W_LLO;
					end
				end
				S_W_LLO: begin
					plen_q[7:0] <= rd_byte;
					state_q <= S_W_LHI;
				end
				S_W_LHI: begin
					plen_q[15:8] <= rd_byte;
					i_q <= '0;
					mism_q <= 1'b0;
					sp_q <= a_q + HDR_C;
					if (a_q + HDR_C >= MEM_END) begin
						if (place_q) begin
							st_q <= STAT_NO_SPACE;
							done_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_LIVE_MISS;
						end
					end else begin
						state_q <= S_W_KEY;
					end
				end
				S_W_KEY: begin
					if (rd_byte == 8'd0) begin
						state_q <= S_W_DEC;
					end else begin
						if ((i_q >= kc_c) || (rd_byte != kb_q[i_q[KI_W-1:0]])) begin
							mism_q <= 1'b1;
						end
						i_q <= i_q + ONE_C;
						sp_q <= sp_q + ONE_C;
						if (sp_q + ONE_C >= MEM_END) begin
							if (place_q) begin
								st_q <= STAT_NO_SPACE;
								done_q <= 1'b1;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_LIVE_MISS;
							end
						end
					end
				end
				S_W_DEC: begin
					if (!place_q) begin
						if (!mark_q[0] && !mism_q && i_q == kc_c) begin
							state_q <= S_LIVE_HIT;
						end else if (anext < MEM_END) begin
							a_q <= anext;
							state_q <= S_W_MARK;
						end else begin
							state_q <= S_LIVE_MISS;
						end
					end else begin
						if (plen_q != '0 && mark_q[0] && (len_c + kc_c == plen_c + i_q)
							&& (a_q + HDR_C + len_c + kc_c < MEM_END)) begin
							state_q <= S_PLACE_HIT;
						end else if (anext < MEM_END && anext + len_c < MEM_END) begin
							a_q <= anext;
							state_q <= S_W_MARK;
						end else begin
							st_q <= STAT_NO_SPACE;
							done_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end
				end
				S_LIVE_HIT: begin
					state_q <= S_EMIT;
					done_q <= 1'b1;
					case (req_q)
						REQ_WRITE: st_q <= STAT_KEY_USED;
						REQ_READ: begin
							ptr_q <= data_start;
							left_q <= len_q;
							if (len_q == '0) begin
								st_q <= STAT_SUCCESS;
							end else begin
								st_q <= STAT_ACCEPTED;
								done_q <= 1'b0;
								phase_q <= PH_READ;
							end
						end
						default: state_q <= S_F_WR;
					endcase
				end
				S_LIVE_MISS: begin
					done_q <= 1'b1;
					if (req_q == REQ_WRITE) begin
						if (len_c < MEM_END) begin
							place_q <= 1'b1;
							a_q <= '0;
							state_q <= S_W_MARK;
						end else begin
							st_q <= STAT_NO_SPACE;
							state_q <= S_EMIT;
						end
					end else begin
						st_q <= STAT_NOT_FOUND;
						state_q <= S_EMIT;
					end
				end
				S_PLACE_HIT: begin
					hcnt_q <= '0;
					state_q <= S_H_WR;
				end
				S_H_WR: begin
					hcnt_q <= hcnt_q + HC_W'(1);
					if (hc_c == HDR_C + kc_c) begin
						ptr_q <= data_start;
						left_q <= len_q;
						state_q <= S_EMIT;
						if (len_q == '0) begin
							st_q <= STAT_SUCCESS;
							done_q <= 1'b1;
						end else begin
							st_q <= STAT_ACCEPTED;
							done_q <= 1'b0;
							phase_q <= PH_WRITE;
						end
					end
				end
				S_F_WR: begin
					st_q <= STAT_SUCCESS;
					done_q <= 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						ost_q <= st_q;
						orb_q <= 8'd0;
						m_tlast <= done_q;
						kc_q <= '0;
						closed_q <= 1'b0;
						over_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KCSA_NEVER(a_no_pop_in_clear, (state_q == S_CLEAR) && q_pop, "item taken during clear")
	`KCSA_NEVER(a_key_count_range, kc_q > KC_W'(KEY_MAX), "key count beyond limit")
	`KCSA_ASSERT(a_key_clear_in_data, ((state_q == S_IDLE) && (phase_q != PH_KEY)) |-> (kc_q == '0), "key not cleared before data")
	`KCSA_ASSERT(a_open_is_accepted, (m_tvalid && !m_tlast) |-> (ost_q == STAT_ACCEPTED), "open result with final status")
endmodule
`default_nettype wire
